### rtl/ts_pkg.sv
// ts_pkg: shared types, codes and coordinate addressing for the texture sampler.
// Used by ts_front, ts_fifo, ts_back and texture_sampler; depends on nothing.
`default_nettype none

package ts_pkg;

  localparam int CFG_SIZE_W = 9;
  localparam int COORD_W    = 24;
  localparam int RGB_W      = 24;
  localparam int CRD_W      = 9;
  localparam int WGT_MAX_W  = 17;
  localparam int ADDR_MAX_W = 24;
  localparam int Q_DEPTH    = 2;

  localparam logic [16:0] Q16_ONE = 17'h10000;

  localparam logic [1:0] MODE_BORDER = 2'd0;
  localparam logic [1:0] MODE_CLAMP  = 2'd1;
  localparam logic [1:0] MODE_MIRROR = 2'd2;
  localparam logic [1:0] MODE_WRAP   = 2'd3;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_FILTER = 3'd3;
  localparam logic [2:0] REG_BORDER = 3'd4;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_BORDER = 2'd1;
  localparam logic [1:0] KIND_POINT  = 2'd2;
  localparam logic [1:0] KIND_FILTER = 2'd3;

  typedef struct packed {
    logic [CFG_SIZE_W-1:0] width;
    logic [CFG_SIZE_W-1:0] height;
    logic [1:0]            mode;
    logic                  filter;
    logic [RGB_W-1:0]      border;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [RGB_W-1:0]      rgb;
    logic [ADDR_MAX_W-1:0] addr;
    logic [CRD_W-1:0]      x0;
    logic [CRD_W-1:0]      x1;
    logic [CRD_W-1:0]      y0;
    logic [CRD_W-1:0]      y1;
    logic [WGT_MAX_W-1:0]  wu;
    logic [WGT_MAX_W-1:0]  wv;
  } entry_t;

  // Fold a signed Q7.16 coordinate into 0..one by the address mode.
  function automatic logic [16:0] addr_coord(input logic signed [COORD_W-1:0] c,
                                             input logic [1:0] mode);
    logic [16:0] t;
    logic [16:0] m2;
    t  = '0;
    m2 = c[16:0];
    unique case (mode)
      MODE_MIRROR: begin
        if (m2 > Q16_ONE) t = 17'(18'h20000 - {1'b0, m2});
        else t = m2;
      end
      MODE_WRAP: begin
        t = {1'b0, c[15:0]};
        if (c[15:0] == 16'd0 && !c[COORD_W-1] && c != '0) t = Q16_ONE;
      end
      default: begin
        if (c[COORD_W-1]) t = '0;
        else if (c > 24'sd65536) t = Q16_ONE;
        else t = c[16:0];
      end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### rtl/texture_sampler.sv
// Path: the front holds each accepted word and the queue carries it to the back sequencer.
// Loads stream at one word per cycle while the back is idle; point, bilinear and border words
// each hold the back until their result is registered; the single-port texel memory takes four reads per bilinear word.
// The front and back are parted by a two-entry queue, so the front keeps accepting while the queue has room.
// Reset (rst_n, synchronous, active low) restores configuration and control state;
// data registers and the texel memory are not cleared; the memory holds garbage until written.
`default_nettype none

module texture_sampler #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic signed [23:0] in_u_coord,
  input  wire logic signed [23:0] in_v_coord,
  input  wire logic [7:0]         in_texel_red,
  input  wire logic [7:0]         in_texel_green,
  input  wire logic [7:0]         in_texel_blue,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic                    out_border_hit
);

  // configuration registers, raw as written
  logic [8:0]  width_r, height_r;
  logic [1:0]  mode_r;
  logic        filter_r;
  logic [23:0] border_r;

  ts_pkg::cfg_t   cfg;
  ts_pkg::entry_t push_entry, pop_entry;
  logic           load_rst, q_push, q_full, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
      mode_r   <= ts_pkg::MODE_BORDER;
      filter_r <= 1'b0;
      border_r <= 24'hFF69B4;
    end else if (cfg_we) begin
      case (cfg_index)
        ts_pkg::REG_WIDTH:  width_r  <= cfg_data[8:0];
        ts_pkg::REG_HEIGHT: height_r <= cfg_data[8:0];
        ts_pkg::REG_MODE:   mode_r   <= cfg_data[1:0];
        ts_pkg::REG_FILTER: filter_r <= cfg_data[0];
        ts_pkg::REG_BORDER: border_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a size write sends the load position home
  assign load_rst = cfg_we && (cfg_index == ts_pkg::REG_WIDTH || cfg_index == ts_pkg::REG_HEIGHT);

  // effective size: zero acts as one, anything above the store's limit is held at it
  always_comb begin
    cfg.width  = width_r;
    cfg.height = height_r;
    if (width_r == 9'd0) cfg.width = 9'd1;
    else if ({4'd0, width_r} > 13'(MAX_WIDTH)) cfg.width = 9'(MAX_WIDTH);
    if (height_r == 9'd0) cfg.height = 9'd1;
    else if ({4'd0, height_r} > 13'(MAX_HEIGHT)) cfg.height = 9'(MAX_HEIGHT);
    cfg.mode   = mode_r;
    cfg.filter = filter_r;
    cfg.border = border_r;
  end

  // front: hold the accepted word, fold coordinates, find taps and weights
  ts_front #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .load_rst       (load_rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_u_coord     (in_u_coord),
    .in_v_coord     (in_v_coord),
    .in_texel_red   (in_texel_red),
    .in_texel_green (in_texel_green),
    .in_texel_blue  (in_texel_blue),
    .q_push         (q_push),
    .q_entry        (push_entry),
    .q_full         (q_full)
  );

  // queue: decouple classification from memory access
  ts_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_entry),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .dout  (pop_entry)
  );

  // back: write texels, read taps one per cycle, blend, drive the result word
  ts_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_border_hit (out_border_hit)
  );

endmodule

`default_nettype wire

### rtl/ts_front.sv
// ts_front: accepts words, applies address modes and computes texel positions and weights.
// Depends on ts_pkg; pushes entries into ts_fifo.
`default_nettype none

module ts_front #(
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ts_pkg::cfg_t        cfg,
  input  wire logic                load_rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_operation,
  input  wire logic signed [23:0]  in_u_coord,
  input  wire logic signed [23:0]  in_v_coord,
  input  wire logic [7:0]          in_texel_red,
  input  wire logic [7:0]          in_texel_green,
  input  wire logic [7:0]          in_texel_blue,
  output logic                     q_push,
  output ts_pkg::entry_t           q_entry,
  input  wire logic                q_full
);

  localparam int WS_W = 17 + WEIGHT_BITS;

  logic               s1_valid_r;
  logic               s1_op_r;
  logic signed [23:0] s1_u_r, s1_v_r;
  logic [23:0]        s1_rgb_r;
  logic [8:0]         col_r, col_nxt;
  logic [8:0]         row_r, row_nxt;

  logic        take, border;
  logic [16:0] ua, va;
  logic [8:0]  mul_u, mul_v, w_last, h_last;
  logic [25:0] prod_u, prod_v;
  logic [9:0]  xr, yr, xi, yi;
  logic [8:0]  x0, x1, y0, y1;
  logic [WS_W-1:0] wsum_u, wsum_v;
  logic        restart;
  logic [8:0]  lc, lr, frow;
  logic [17:0] prod_l;
  logic [18:0] laddr;

  assign q_push   = s1_valid_r && !q_full;
  assign in_stall = s1_valid_r && !q_push;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (q_push) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op_r  <= in_operation;
      s1_u_r   <= in_u_coord;
      s1_v_r   <= in_v_coord;
      s1_rgb_r <= {in_texel_red, in_texel_green, in_texel_blue};
    end
  end

  always_comb begin
    ua     = ts_pkg::addr_coord(s1_u_r, cfg.mode);
    va     = ts_pkg::addr_coord(s1_v_r, cfg.mode);
    border = (cfg.mode == ts_pkg::MODE_BORDER) &&
             (s1_u_r < 0 || s1_u_r > 24'sd65536 || s1_v_r < 0 || s1_v_r > 24'sd65536);
    w_last = cfg.width - 9'd1;
    h_last = cfg.height - 9'd1;
    mul_u  = cfg.filter ? cfg.width : w_last;
    mul_v  = cfg.filter ? cfg.height : h_last;
    prod_u = {9'd0, ua} * {17'd0, mul_u};
    prod_v = {9'd0, va} * {17'd0, mul_v};
    xr = prod_u[25:16];
    yr = prod_v[25:16];
    xi = xr + 10'd1;
    yi = yr + 10'd1;
    // clamp both taps to the last texel
    x0 = (xr > {1'b0, w_last}) ? w_last : xr[8:0];
    x1 = (xi > {1'b0, w_last}) ? w_last : xi[8:0];
    y0 = (yr > {1'b0, h_last}) ? h_last : yr[8:0];
    y1 = (yi > {1'b0, h_last}) ? h_last : yi[8:0];
    wsum_u = {1'b0, prod_u[15:0], {WEIGHT_BITS{1'b0}}} + WS_W'(32768);
    wsum_v = {1'b0, prod_v[15:0], {WEIGHT_BITS{1'b0}}} + WS_W'(32768);

    // load position, bottom row first
    restart = (col_r >= cfg.width) || (row_r >= cfg.height);
    lc      = restart ? 9'd0 : col_r;
    lr      = restart ? 9'd0 : row_r;
    frow    = h_last - lr;
    prod_l  = {9'd0, frow} * {9'd0, cfg.width};
    laddr   = {1'b0, prod_l} + {10'd0, lc};

    col_nxt = col_r;
    row_nxt = row_r;
    if (load_rst) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (q_push && !s1_op_r) begin
      if ({1'b0, lc} + 10'd1 >= {1'b0, cfg.width}) begin
        col_nxt = '0;
        row_nxt = ({1'b0, lr} + 10'd1 >= {1'b0, cfg.height}) ? 9'd0 : lr + 9'd1;
      end else begin
        col_nxt = lc + 9'd1;
      end
    end

    q_entry      = '0;
    q_entry.addr = 24'(laddr);
    q_entry.x0   = x0;
    q_entry.x1   = x1;
    q_entry.y0   = y0;
    q_entry.y1   = y1;
    q_entry.wu   = 17'(wsum_u[WS_W-1:16]);
    q_entry.wv   = 17'(wsum_v[WS_W-1:16]);
    q_entry.rgb  = s1_op_r ? cfg.border : s1_rgb_r;
    if (!s1_op_r) q_entry.kind = ts_pkg::KIND_LOAD;
    else if (border) q_entry.kind = ts_pkg::KIND_BORDER;
    else if (cfg.filter) q_entry.kind = ts_pkg::KIND_FILTER;
    else q_entry.kind = ts_pkg::KIND_POINT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/ts_fifo.sv
// ts_fifo: short entry queue between the front and back of the sampler.
// Depends on ts_pkg for the entry type and depth.
`default_nettype none

module ts_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ts_pkg::entry_t din,
  output logic                full,
  output logic                valid,
  input  wire logic           pop,
  output ts_pkg::entry_t      dout
);

  localparam int PW = (ts_pkg::Q_DEPTH > 1) ? $clog2(ts_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(ts_pkg::Q_DEPTH + 1);

  ts_pkg::entry_t slot_r [ts_pkg::Q_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;

  assign full  = (cnt_r == CW'(ts_pkg::Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(ts_pkg::Q_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(ts_pkg::Q_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/ts_back.sv
// ts_back: texel memory, read sequencer, bilinear blend and output register.
// Depends on ts_pkg; pops entries from ts_fifo.
`default_nettype none

module ts_back #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ts_pkg::cfg_t   cfg,
  input  wire logic           q_valid,
  input  wire ts_pkg::entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic                out_border_hit
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WB    = WEIGHT_BITS;
  localparam int TW    = WB + 10;
  localparam int SW    = TW + WB + 2;
  localparam int FULL  = 1 << WB;
  localparam logic [SW-1:0] HALF = SW'(1) << (2 * WB - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_GATHER = 3'd2;
  localparam logic [2:0] ST_LERP   = 3'd3;
  localparam logic [2:0] ST_MIX    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [23:0] mem [DEPTH];
  logic [23:0] mem_q;

  logic [2:0]     st_r, st_nxt;
  ts_pkg::entry_t ent_r, ent_nxt;
  logic [1:0]     rd_idx_r, rd_idx_nxt;
  logic           cap_en_r, cap_en_nxt;
  logic [1:0]     cap_idx_r, cap_idx_nxt;
  logic [23:0]    tex_r [4];
  logic [TW-1:0]  top_r [3];
  logic [TW-1:0]  bot_r [3];
  logic [TW-1:0]  top_nxt [3];
  logic [TW-1:0]  bot_nxt [3];
  logic [23:0]    res_r, res_nxt;
  logic           hit_r, hit_nxt;
  logic           out_valid_r;
  logic [23:0]    out_rgb_r;
  logic           out_hit_r;

  logic          out_free, mem_we, lerp_en;
  logic [1:0]    last_idx;
  logic [8:0]    rd_x, rd_y;
  logic [18:0]   rd_lin;
  logic [AW-1:0] mem_addr;
  logic [WB:0]   wu, wv, inv_u, inv_v;
  logic [SW-1:0] sum [3];
  logic [SW-1:0] rnd [3];
  logic [23:0]   blend;

  assign out_free = !out_valid_r || !out_stall;
  assign mem_we   = (st_r == ST_IDLE) && q_valid && (q_entry.kind == ts_pkg::KIND_LOAD);
  assign q_pop    = (st_r == ST_IDLE) && q_valid;
  assign last_idx = (ent_r.kind == ts_pkg::KIND_FILTER) ? 2'd3 : 2'd0;
  assign lerp_en  = (st_r == ST_LERP);

  // tap order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  assign rd_x     = rd_idx_r[0] ? ent_r.x1 : ent_r.x0;
  assign rd_y     = rd_idx_r[1] ? ent_r.y1 : ent_r.y0;
  assign rd_lin   = {1'b0, {9'd0, rd_y} * {9'd0, cfg.width}} + {10'd0, rd_x};
  assign mem_addr = mem_we ? AW'(q_entry.addr) : AW'(rd_lin);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= q_entry.rgb;
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cap_en_r) tex_r[cap_idx_r] <= mem_q;
  end

  always_comb begin
    wu    = ent_r.wu[WB:0];
    wv    = ent_r.wv[WB:0];
    inv_u = (WB + 1)'(FULL) - wu;
    inv_v = (WB + 1)'(FULL) - wv;
    blend = '0;
    for (int ch = 0; ch < 3; ch++) begin
      top_nxt[ch] = TW'(tex_r[0][8*ch +: 8]) * TW'(inv_u) + TW'(tex_r[1][8*ch +: 8]) * TW'(wu);
      bot_nxt[ch] = TW'(tex_r[2][8*ch +: 8]) * TW'(inv_u) + TW'(tex_r[3][8*ch +: 8]) * TW'(wu);
      sum[ch]     = SW'(top_r[ch]) * SW'(inv_v) + SW'(bot_r[ch]) * SW'(wv);
      rnd[ch]     = (sum[ch] + HALF) >> (2 * WB);
      blend[8*ch +: 8] = (rnd[ch] > SW'(255)) ? 8'hFF : rnd[ch][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (lerp_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        top_r[ch] <= top_nxt[ch];
        bot_r[ch] <= bot_nxt[ch];
      end
    end
  end

  always_comb begin
    st_nxt      = st_r;
    ent_nxt     = ent_r;
    rd_idx_nxt  = rd_idx_r;
    cap_en_nxt  = 1'b0;
    cap_idx_nxt = cap_idx_r;
    res_nxt     = res_r;
    hit_nxt     = hit_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_entry.kind)
            ts_pkg::KIND_BORDER: begin
              res_nxt = q_entry.rgb;
              hit_nxt = 1'b1;
              st_nxt  = ST_DONE;
            end
            ts_pkg::KIND_POINT, ts_pkg::KIND_FILTER: begin
              ent_nxt    = q_entry;
              rd_idx_nxt = '0;
              st_nxt     = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cap_en_nxt  = 1'b1;
        cap_idx_nxt = rd_idx_r;
        if (rd_idx_r == last_idx) st_nxt = ST_GATHER;
        else rd_idx_nxt = rd_idx_r + 2'd1;
      end
      ST_GATHER: begin
        if (ent_r.kind == ts_pkg::KIND_FILTER) begin
          st_nxt = ST_LERP;
        end else begin
          res_nxt = mem_q;
          hit_nxt = 1'b0;
          st_nxt  = ST_DONE;
        end
      end
      ST_LERP: st_nxt = ST_MIX;
      ST_MIX: begin
        res_nxt = blend;
        hit_nxt = 1'b0;
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rd_idx_r    <= '0;
      cap_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      rd_idx_r <= rd_idx_nxt;
      cap_en_r <= cap_en_nxt;
      if (st_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ent_r     <= ent_nxt;
    cap_idx_r <= cap_idx_nxt;
    res_r     <= res_nxt;
    hit_r     <= hit_nxt;
    if (st_r == ST_DONE && out_free) begin
      out_rgb_r <= res_r;
      out_hit_r <= hit_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_rgb_r[23:16];
  assign out_green      = out_rgb_r[15:8];
  assign out_blue       = out_rgb_r[7:0];
  assign out_border_hit = out_hit_r;

`ifndef SYNTHESIS
  a_cap_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cap_en_r |-> $past(st_r) == ST_READ) else $error("capture without read");
  a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !cap_en_r) else $error("texel write during read sequence");
  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && out_free) |=> out_valid_r) else $error("result dropped");
  a_read_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_READ) |-> (ent_r.kind == ts_pkg::KIND_POINT ||
                           ent_r.kind == ts_pkg::KIND_FILTER))
    else $error("read sequence for wrong entry kind");
`endif

endmodule

`default_nettype wire
